[design/gcd_pkg.sv]
package gcd_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_W        = 6;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 16;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    typedef enum logic [1:0] {
        OP_ADD_NODE = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_CHECK    = 2'd2,
        OP_CLEAR    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_UNKNOWN     = 3'd2,
        ST_SELF_LOOP   = 3'd3,
        ST_EDGE_EXISTS = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EDGE_CHK,
        S_EDGE_REV,
        S_ROOT,
        S_SCAN,
        S_POP,
        S_RESULT
    } t_state;

    // source of the adjacency row read address
    typedef enum logic [2:0] {
        ADJ_RD_NONE,
        ADJ_RD_SRC,
        ADJ_RD_DST,
        ADJ_RD_FOUND,
        ADJ_RD_ROOT,
        ADJ_RD_STACK
    } t_adj_rd;

    typedef struct packed {
        logic    load_item;
        logic    node_add;
        logic    graph_clr;
        t_adj_rd adj_rd;
        logic    wr_fwd;
        logic    wr_rev;
        logic    chk_init;
        logic    root_start;
        logic    skip;
        logic    push;
        logic    pop;
        logic    restore;
        logic    res_set;
        t_status res_status;
        logic    res_cyc;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    directed;
        logic    full;
        logic    unknown;
        logic    self_loop;
        logic    edge_exists;
        logic    no_root;
        logic    cand_none;
        logic    hit_cycle;
        logic    cand_new;
        logic    depth_one;
        logic    out_busy;
    } t_sts;

endpackage

[design/gcd_ctrl.sv]
module gcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gcd_pkg::t_sts i_sts,
    output gcd_pkg::t_cmd o_cmd
);
    import gcd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.adj_rd     = ADJ_RD_NONE;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_ADD_NODE: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.node_add = 1'b1;
                        end
                        n_state = S_RESULT;
                    end
                    OP_ADD_EDGE: begin
                        if (i_sts.unknown) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_UNKNOWN;
                            n_state          = S_RESULT;
                        end else if (i_sts.self_loop) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = ST_SELF_LOOP;
                            n_state          = S_RESULT;
                        end else begin
                            o_cmd.adj_rd = ADJ_RD_SRC;
                            n_state      = S_EDGE_CHK;
                        end
                    end
                    OP_CHECK: begin
                        o_cmd.chk_init = 1'b1;
                        n_state        = S_ROOT;
                    end
                    OP_CLEAR: begin
                        o_cmd.graph_clr = 1'b1;
                        o_cmd.res_set   = 1'b1;
                        n_state         = S_RESULT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EDGE_CHK: begin
                if (i_sts.edge_exists) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_EDGE_EXISTS;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.wr_fwd = 1'b1;
                    if (i_sts.directed) begin
                        o_cmd.res_set = 1'b1;
                        n_state       = S_RESULT;
                    end else begin
                        // fetch the reverse row while the forward one is written
                        o_cmd.adj_rd = ADJ_RD_DST;
                        n_state      = S_EDGE_REV;
                    end
                end
            end
            S_EDGE_REV: begin
                o_cmd.wr_rev  = 1'b1;
                o_cmd.res_set = 1'b1;
                n_state       = S_RESULT;
            end
            S_ROOT: begin
                if (i_sts.no_root) begin
                    o_cmd.res_set = 1'b1;
                    n_state       = S_RESULT;
                end else begin
                    o_cmd.root_start = 1'b1;
                    o_cmd.adj_rd     = ADJ_RD_ROOT;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.cand_none) begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_sts.depth_one ? S_ROOT : S_POP;
                end else if (i_sts.hit_cycle) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_cyc = 1'b1;
                    n_state       = S_RESULT;
                end else if (i_sts.cand_new) begin
                    o_cmd.push   = 1'b1;
                    o_cmd.adj_rd = ADJ_RD_FOUND;
                end else begin
                    o_cmd.skip = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.restore = 1'b1;
                o_cmd.adj_rd  = ADJ_RD_STACK;
                n_state       = S_SCAN;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/gcd_dpath.sv]
module gcd_dpath #(
    parameter int MAX_NODES = gcd_pkg::MAX_NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_directed,
    input  gcd_pkg::t_opcode             i_op,
    input  logic [gcd_pkg::NODE_W-1:0]   i_src,
    input  logic [gcd_pkg::NODE_W-1:0]   i_dst,
    input  gcd_pkg::t_cmd                i_cmd,
    output gcd_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output gcd_pkg::t_status             o_out_status,
    output logic [gcd_pkg::NODE_W-1:0]   o_out_index,
    output logic                         o_out_cyc
);
    import gcd_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef struct packed {
        logic [NW-1:0] par;
        logic [CW-1:0] nxt;
        logic [NW-1:0] node;
    } t_frame;

    // latched item
    t_opcode             r_op;
    logic [NODE_W-1:0]   r_src;
    logic [NODE_W-1:0]   r_dst;

    logic [CW-1:0]       r_count;

    // adjacency rows, one valid bit per row
    logic [MAX_NODES-1:0] r_adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_adj_rd;
    logic                 r_adj_rd_vld;
    logic [MAX_NODES-1:0] r_row_vld;

    // search stack below the current frame
    t_frame               r_stk_mem [MAX_NODES];
    t_frame               r_stk_rd;

    logic [MAX_NODES-1:0] r_visited;
    logic [MAX_NODES-1:0] r_on_path;
    logic [NW-1:0]        r_cur_node;
    logic [NW-1:0]        r_cur_par;
    logic [CW-1:0]        r_cur_next;
    logic [CW-1:0]        r_depth;

    t_status              r_res_status;
    logic [NODE_W-1:0]    r_res_index;
    logic                 r_res_cyc;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [NODE_W-1:0]    r_out_index;
    logic                 r_out_cyc;

    logic [NW-1:0]        src_n;
    logic [NW-1:0]        dst_n;
    logic [MAX_NODES-1:0] known;
    logic [MAX_NODES-1:0] row;
    logic [MAX_NODES-1:0] ge_next;
    logic [MAX_NODES-1:0] cand;
    logic [MAX_NODES-1:0] unvisited;
    logic [NW-1:0]        found;
    logic [NW-1:0]        root;
    logic [CW-1:0]        found_inc;

    logic                 adj_re;
    logic [NW-1:0]        adj_ra;
    logic                 adj_we;
    logic [NW-1:0]        adj_wa;
    logic [MAX_NODES-1:0] adj_wd;
    logic [NW-1:0]        stk_wa;
    logic [NW-1:0]        stk_ra;
    t_frame               stk_wd;

    assign src_n     = r_src[NW-1:0];
    assign dst_n     = r_dst[NW-1:0];
    assign found_inc = CW'(found) + CW'(1);

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            known[i]   = (CW'(i) < r_count);
            ge_next[i] = (CW'(i) >= r_cur_next);
        end
    end

    assign row       = r_adj_rd & {MAX_NODES{r_adj_rd_vld}} & known;
    assign cand      = row & ge_next;
    assign unvisited = ~r_visited & known;

    // lowest set bit wins
    always_comb begin
        found = '0;
        root  = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found = NW'(i);
            end
            if (unvisited[i]) begin
                root = NW'(i);
            end
        end
    end

    always_comb begin
        o_sts.op          = r_op;
        o_sts.directed    = i_directed;
        o_sts.full        = (r_count == CW'(MAX_NODES));
        o_sts.unknown     = ({1'b0, r_src} >= 7'(r_count)) || ({1'b0, r_dst} >= 7'(r_count));
        o_sts.self_loop   = (r_src == r_dst);
        o_sts.edge_exists = r_adj_rd[dst_n] & r_adj_rd_vld;
        o_sts.no_root     = ~|unvisited;
        o_sts.cand_none   = ~|cand;
        // directed: back edge onto the path; undirected: visited node other than the parent
        o_sts.hit_cycle   = i_directed ? r_on_path[found]
                          : (r_visited[found]
                             && !((r_depth > CW'(1)) && (r_cur_par == found)));
        o_sts.cand_new    = ~r_visited[found];
        o_sts.depth_one   = (r_depth == CW'(1));
        o_sts.out_busy    = r_out_valid & ~i_out_ready;
    end

    always_comb begin
        adj_re = (i_cmd.adj_rd != ADJ_RD_NONE);
        case (i_cmd.adj_rd)
            ADJ_RD_SRC:   adj_ra = src_n;
            ADJ_RD_DST:   adj_ra = dst_n;
            ADJ_RD_FOUND: adj_ra = found;
            ADJ_RD_ROOT:  adj_ra = root;
            ADJ_RD_STACK: adj_ra = r_stk_rd.node;
            default:      adj_ra = '0;
        endcase
        adj_we = i_cmd.wr_fwd | i_cmd.wr_rev;
        if (i_cmd.wr_rev) begin
            adj_wa = dst_n;
            adj_wd = (r_adj_rd & {MAX_NODES{r_adj_rd_vld}})
                   | ({{(MAX_NODES-1){1'b0}}, 1'b1} << src_n);
        end else begin
            adj_wa = src_n;
            adj_wd = (r_adj_rd & {MAX_NODES{r_adj_rd_vld}})
                   | ({{(MAX_NODES-1){1'b0}}, 1'b1} << dst_n);
        end
    end

    assign stk_wa = NW'(r_depth - CW'(1));
    assign stk_ra = NW'(r_depth - CW'(2));
    assign stk_wd = '{par: r_cur_par, nxt: found_inc, node: r_cur_node};

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[adj_wa] <= adj_wd;
        end
        if (adj_re) begin
            r_adj_rd     <= r_adj_mem[adj_ra];
            r_adj_rd_vld <= r_row_vld[adj_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        if (i_cmd.pop) begin
            r_stk_rd <= r_stk_mem[stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_op;
            r_src <= i_src;
            r_dst <= i_dst;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_index  <= i_cmd.node_add ? NODE_W'(r_count) : '0;
            r_res_cyc    <= i_cmd.res_cyc;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_cyc    <= r_res_cyc;
        end
        if (i_cmd.root_start) begin
            r_cur_node <= root;
            r_cur_par  <= root;
            r_cur_next <= '0;
        end else if (i_cmd.push) begin
            r_cur_node <= found;
            r_cur_par  <= r_cur_node;
            r_cur_next <= '0;
        end else if (i_cmd.skip) begin
            r_cur_next <= found_inc;
        end else if (i_cmd.restore) begin
            r_cur_node <= r_stk_rd.node;
            r_cur_par  <= r_stk_rd.par;
            r_cur_next <= r_stk_rd.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_row_vld   <= '0;
            r_visited   <= '0;
            r_on_path   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.graph_clr) begin
                r_count   <= '0;
                r_row_vld <= '0;
            end else begin
                if (i_cmd.node_add) begin
                    r_count <= r_count + CW'(1);
                end
                if (adj_we) begin
                    r_row_vld[adj_wa] <= 1'b1;
                end
            end

            if (i_cmd.graph_clr || i_cmd.chk_init) begin
                r_visited <= '0;
                r_on_path <= '0;
            end else if (i_cmd.root_start) begin
                r_visited[root] <= 1'b1;
                r_on_path       <= {{(MAX_NODES-1){1'b0}}, 1'b1} << root;
            end else if (i_cmd.push) begin
                r_visited[found] <= 1'b1;
                r_on_path[found] <= 1'b1;
            end else if (i_cmd.pop) begin
                r_on_path[r_cur_node] <= 1'b0;
            end

            if (i_cmd.root_start) begin
                r_depth <= CW'(1);
            end else if (i_cmd.push) begin
                r_depth <= r_depth + CW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= r_depth - CW'(1);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_index  = r_out_index;
    assign o_out_cyc    = r_out_cyc;

endmodule

[design/graph_cycle_detector.sv]
// Graph cycle detector: a graph of up to MAX_NODES nodes held as an adjacency bit matrix.
// Input stream: one operation per transfer, opcode on s_axis_tuser (add node, add edge,
// check for cycle, clear), edge end points on s_axis_tdata. Output stream: exactly one
// result per operation (status, index of a new node, cycle flag), in order.
// APB register 0 selects directed (1, reset value) or undirected (0) graphs; write it
// only while the block is idle.
// Add edge writes the edge both ways in undirected mode. A check is a depth-first search
// driven by a state machine over a row memory with one read and one write port and a
// stack memory: each root is taken up in the root state, each node pushed is left again
// by a backtrack through the pop state, and each neighbour skipped takes a scan step.
// Only one operation is in flight; s_axis_tready is high while the block is idle, in the
// cycle after a result is loaded.
// A result waits in the output register while m_axis_tready is low; the next item
// is accepted and executed meanwhile, and its result is held until the register frees.
// Reset (synchronous, active low) empties the graph and the output register and sets
// directed mode; no memory sweep is needed, row valid bits stand for the cleared rows.
module graph_cycle_detector #(
    parameter int MAX_NODES = gcd_pkg::MAX_NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // src_node[5:0], dest_node[11:6]
    input  logic [1:0]                       s_axis_tuser,  // opcode[1:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // status[2:0], node_index[8:3],
                                                            // has_cycle[9]
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gcd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gcd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gcd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import gcd_pkg::*;

    logic              r_directed;
    logic              cfg_wr;
    logic              reg_sel;
    t_cmd              cmd;
    t_sts              sts;
    t_status           out_status;
    logic [NODE_W-1:0] out_index;
    logic              out_cyc;

    assign pready  = 1'b1;
    assign reg_sel = ~paddr[APB_ADDR_W-1];
    assign cfg_wr  = psel & penable & pwrite & reg_sel;
    assign prdata  = reg_sel ? {{(APB_DATA_W-1){1'b0}}, r_directed} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed <= 1'b1;
        end else if (cfg_wr) begin
            r_directed <= pwdata[0];
        end
    end

    gcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gcd_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_directed   (r_directed),
        .i_op         (t_opcode'(s_axis_tuser)),
        .i_src        (s_axis_tdata[NODE_W-1:0]),
        .i_dst        (s_axis_tdata[2*NODE_W-1:NODE_W]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (out_status),
        .o_out_index  (out_index),
        .o_out_cyc    (out_cyc)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-NODE_W-4){1'b0}}, out_cyc, out_index, out_status};

endmodule
